// ===== design/pcf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared constants, codes and controller/datapath interface types for the
// capture register block with sample FIFO.
// ----------------------------------------------------------------------------
package pcf_pkg;

  localparam int PCF_FIFO_DEPTH = 64;
  localparam int PCF_REG_COUNT  = 64;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  localparam logic [11:0] OFS_CTRL1    = 12'h000;
  localparam logic [11:0] OFS_STAT     = 12'h008;
  localparam logic [11:0] OFS_FIFOCTL  = 12'h010;
  localparam logic [11:0] OFS_FIFOSTAT = 12'h014;
  localparam logic [11:0] OFS_DATA_LO  = 12'h024;
  localparam logic [11:0] OFS_DATA_HI  = 12'h040;
  localparam logic [11:0] OFS_IDENT    = 12'h084;
  localparam logic [11:0] OFS_CAPS     = 12'h088;

  localparam logic [9:0] WORD_CTRL1   = OFS_CTRL1[11:2];
  localparam logic [9:0] WORD_FIFOCTL = OFS_FIFOCTL[11:2];

  localparam logic [31:0] IDENT_VALUE = 32'h020F_0000;
  localparam logic [31:0] CAPS_VALUE  = 32'h0000_0154;

  localparam int BIT_DISABLE = 31;
  localparam int BIT_ENABLE  = 29;
  localparam int BIT_SOFTRST = 27;
  localparam int SEL_LSB     = 24;
  localparam logic [1:0] SEL_DMA = 2'b01;
  localparam int WMK_W       = 5;

  typedef struct packed {
    logic clr;
    logic cap;
    logic exec;
  } pcf_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } pcf_sts_t;

endpackage
`default_nettype wire

// ===== design/pdm_capture_fifo_registers.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdm_capture_fifo_registers
// Capture register block with sample FIFO: ticks, register reads and writes.
// ----------------------------------------------------------------------------
// The result is registered after the capture and execute steps, and comes
// later while the previous result waits.
// One beat is taken at a time: capture with memory read, then execute.
// The result register frees the input side while a result waits.
// Reset: after rst_n the register file is swept to zero, one word a cycle,
// with in_ready low until the last word is cleared.
module pdm_capture_fifo_registers
  import pcf_pkg::*;
#(
  parameter int FIFO_DEPTH = PCF_FIFO_DEPTH,
  parameter int REG_COUNT  = PCF_REG_COUNT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [11:0] in_offset,
  input  wire logic [31:0] in_wdata,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_rdata,
  output logic             out_dma_request
);

  pcf_cmd_t cmd;
  pcf_sts_t sts;

  pcf_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  pcf_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .REG_COUNT  (REG_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_kind         (in_kind),
    .in_offset       (in_offset),
    .in_wdata        (in_wdata),
    .out_ready       (out_ready),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_rdata       (out_rdata),
    .out_dma_request (out_dma_request)
  );

endmodule
`default_nettype wire

// ===== design/pcf_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcf_controller
// Sequencer: register clear sweep after reset, then capture and execute of
// one item at a time.
// ----------------------------------------------------------------------------
module pcf_controller
  import pcf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire pcf_sts_t sts,
  output logic          in_ready,
  output pcf_cmd_t      cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.cap  = in_valid;
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/pcf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcf_datapath
// Register file memory, sample FIFO memory with indexes and fill count,
// sawtooth generator, item registers and the result register.
// ----------------------------------------------------------------------------
module pcf_datapath
  import pcf_pkg::*;
#(
  parameter int FIFO_DEPTH = PCF_FIFO_DEPTH,
  parameter int REG_COUNT  = PCF_REG_COUNT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [1:0]  in_kind,
  input  wire logic [11:0] in_offset,
  input  wire logic [31:0] in_wdata,
  input  wire logic        out_ready,
  input  wire pcf_cmd_t    cmd,
  output pcf_sts_t         sts,
  output logic             out_valid,
  output logic [31:0]      out_rdata,
  output logic             out_dma_request
);

  localparam int RA = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int FA = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FC = $clog2(FIFO_DEPTH + 1);
  localparam int CW = (FC > WMK_W) ? FC : WMK_W;

  logic [31:0] reg_mem [REG_COUNT];
  logic [31:0] smp_mem [FIFO_DEPTH];

  logic [1:0]   kind_r;
  logic [11:0]  off_r;
  logic [31:0]  wdata_r;
  logic [31:0]  reg_rdata_r;
  logic [31:0]  smp_rdata_r;

  logic [RA-1:0] clr_idx_r;
  logic [FA-1:0] rd_idx_r, rd_idx_nxt;
  logic [FA-1:0] wr_idx_r, wr_idx_nxt;
  logic [FC-1:0] fill_r, fill_nxt;
  logic [6:0]    phase_r, phase_nxt;

  logic          ctl_dis_r, ctl_en_r;
  logic [1:0]    ctl_sel_r;
  logic [WMK_W-1:0] wmk_r;

  logic          out_valid_r;
  logic [31:0]   out_rdata_r;
  logic          out_dma_r;
  logic [31:0]   rdata_nxt;
  logic          dma_nxt;

  logic          mem_we;
  logic [RA-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          smp_we;

  logic          in_word_ok;
  logic          word_ok;
  logic          is_data;
  logic          running;
  logic          ctl_run_new;
  logic [15:0]   half;
  logic [31:0]   new_word;
  logic [31:0]   new_ctrl;
  logic          drain;

  assign in_word_ok = 32'(in_offset[11:2]) < 32'(REG_COUNT);
  assign word_ok    = 32'(off_r[11:2]) < 32'(REG_COUNT);
  assign is_data    = (off_r >= OFS_DATA_LO) && (off_r <= OFS_DATA_HI);
  assign running    = ctl_en_r && !ctl_dis_r;
  assign half       = {phase_r, 9'd0};
  assign new_word   = {half, half};
  assign new_ctrl   = wdata_r & ~(32'd1 << BIT_SOFTRST);
  assign ctl_run_new = new_ctrl[BIT_ENABLE] && !new_ctrl[BIT_DISABLE];

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    fill_nxt   = fill_r;
    phase_nxt  = phase_r;
    rdata_nxt  = '0;
    dma_nxt    = 1'b0;
    smp_we     = 1'b0;
    drain      = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = off_r[RA+1:2];
    mem_wdata  = wdata_r;
    if (cmd.clr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else if (cmd.exec) begin
      unique case (kind_r)
        KIND_TICK: begin
          if (running) begin
            if (fill_r != FC'(FIFO_DEPTH)) begin
              smp_we     = 1'b1;
              wr_idx_nxt = (wr_idx_r == FA'(FIFO_DEPTH - 1)) ? '0 : wr_idx_r + 1'b1;
              fill_nxt   = fill_r + 1'b1;
              phase_nxt  = phase_r + 1'b1;
            end
            dma_nxt = (ctl_sel_r == SEL_DMA) && (CW'(fill_nxt) > CW'(wmk_r));
          end
        end
        KIND_READ: begin
          priority if (off_r == OFS_IDENT) begin
            rdata_nxt = IDENT_VALUE;
          end else if (off_r == OFS_CAPS) begin
            rdata_nxt = CAPS_VALUE;
          end else if (off_r == OFS_STAT || off_r == OFS_FIFOSTAT) begin
            rdata_nxt = '0;
          end else if (is_data) begin
            if (fill_r != '0) begin
              rdata_nxt  = smp_rdata_r;
              rd_idx_nxt = (rd_idx_r == FA'(FIFO_DEPTH - 1)) ? '0 : rd_idx_r + 1'b1;
              fill_nxt   = fill_r - 1'b1;
            end else if (running) begin
              rdata_nxt = new_word;
              phase_nxt = phase_r + 1'b1;
            end
          end else if (word_ok) begin
            rdata_nxt = reg_rdata_r;
          end else begin
            rdata_nxt = '0;
          end
        end
        KIND_WRITE: begin
          priority if (off_r == OFS_IDENT || off_r == OFS_CAPS) begin
            mem_we = 1'b0;
          end else if (off_r == OFS_CTRL1) begin
            mem_we    = 1'b1;
            mem_wdata = new_ctrl;
            drain     = wdata_r[BIT_SOFTRST] || (ctl_run_new != running);
          end else begin
            mem_we = word_ok;
          end
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
      if (drain) begin
        rd_idx_nxt = '0;
        wr_idx_nxt = '0;
        fill_nxt   = '0;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (mem_we) reg_mem[mem_waddr] <= mem_wdata;
    if (cmd.cap && in_word_ok) reg_rdata_r <= reg_mem[in_offset[RA+1:2]];
  end

  always_ff @(posedge clk) begin
    if (smp_we) smp_mem[wr_idx_r] <= new_word;
    if (cmd.cap) smp_rdata_r <= smp_mem[rd_idx_r];
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      kind_r  <= in_kind;
      off_r   <= in_offset;
      wdata_r <= in_wdata;
    end
    if (cmd.exec) begin
      out_rdata_r <= rdata_nxt;
      out_dma_r   <= dma_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      fill_r      <= '0;
      phase_r     <= '0;
      ctl_dis_r   <= 1'b0;
      ctl_en_r    <= 1'b0;
      ctl_sel_r   <= '0;
      wmk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_idx_r <= clr_idx_r + 1'b1;
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
      fill_r   <= fill_nxt;
      phase_r  <= phase_nxt;
      if (mem_we && 10'(mem_waddr) == WORD_CTRL1) begin
        ctl_dis_r <= mem_wdata[BIT_DISABLE];
        ctl_en_r  <= mem_wdata[BIT_ENABLE];
        ctl_sel_r <= mem_wdata[SEL_LSB+1:SEL_LSB];
      end
      if (mem_we && 10'(mem_waddr) == WORD_FIFOCTL) begin
        wmk_r <= mem_wdata[WMK_W-1:0];
      end
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.clr_last = (clr_idx_r == RA'(REG_COUNT - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_rdata       = out_rdata_r;
  assign out_dma_request = out_dma_r;

endmodule
`default_nettype wire

// ===== verif/tb_pdm_capture_fifo_registers.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pdm_capture_fifo_registers
// Self-checking bench for the capture register block with sample FIFO.
// Every accepted beat runs through a shadow copy of the registers and the
// sample FIFO. The result it yields is queued and compared field by field
// with each result beat. Directed tests cover the register map, the stopped
// block, run/stop/soft reset and the DMA watermark. A long receiver hold
// stalls the input, and a run of ticks fills the FIFO. Random traffic then runs under
// several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_pdm_capture_fifo_registers;
  import pcf_pkg::*;

  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [31:0] rdata;
    logic        dma_request;
  } capture_result_t;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic [1:0]  in_kind         = KIND_TICK;
  logic [11:0] in_offset       = 12'h000;
  logic [31:0] in_wdata        = 32'h0;
  logic        out_ready       = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] out_rdata;
  logic        out_dma_request;

  int error_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_arm     = 1'b0;
  logic hold_done    = 1'b0;
  int hold_left      = 0;

  capture_result_t awaited_results[$];

  logic [31:0] shadow_regs [PCF_REG_COUNT];
  logic [31:0] shadow_fifo [PCF_FIFO_DEPTH];
  int unsigned fifo_rd_ptr = 0;
  int unsigned fifo_wr_ptr = 0;
  int unsigned fifo_fill   = 0;
  logic [6:0]  saw_phase   = 7'd0;

  pdm_capture_fifo_registers u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_offset       (in_offset),
    .in_wdata        (in_wdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_rdata       (out_rdata),
    .out_dma_request (out_dma_request)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic block_running();
    logic [31:0] c;
    c = shadow_regs[WORD_CTRL1];
    return c[BIT_ENABLE] && !c[BIT_DISABLE];
  endfunction

  function automatic logic [31:0] next_sawtooth();
    logic [15:0] h;
    h = {saw_phase, 9'b0};
    saw_phase = saw_phase + 7'd1;
    return {h, h};
  endfunction

  function automatic void drain_fifo();
    fifo_rd_ptr = 0;
    fifo_wr_ptr = 0;
    fifo_fill   = 0;
  endfunction

  function automatic capture_result_t predict_capture(logic [1:0] kind, logic [11:0] ofs,
                                                      logic [31:0] wdata);
    capture_result_t res;
    logic [4:0]  wmk;
    logic        dma_sel;
    logic        prior_run;
    logic [31:0] ctrl_new;
    res = '0;
    case (kind)
      KIND_TICK: begin
        wmk     = shadow_regs[WORD_FIFOCTL][WMK_W-1:0];
        dma_sel = shadow_regs[WORD_CTRL1][SEL_LSB +: 2] == SEL_DMA;
        if (block_running()) begin
          if (fifo_fill < PCF_FIFO_DEPTH) begin
            shadow_fifo[fifo_wr_ptr] = next_sawtooth();
            fifo_wr_ptr = (fifo_wr_ptr + 1) % PCF_FIFO_DEPTH;
            fifo_fill++;
          end
          res.dma_request = dma_sel && (fifo_fill > wmk);
        end
      end
      KIND_READ: begin
        if (ofs == OFS_IDENT) res.rdata = IDENT_VALUE;
        else if (ofs == OFS_CAPS) res.rdata = CAPS_VALUE;
        else if (ofs == OFS_STAT || ofs == OFS_FIFOSTAT) res.rdata = '0;
        else if (ofs >= OFS_DATA_LO && ofs <= OFS_DATA_HI) begin
          if (fifo_fill > 0) begin
            res.rdata = shadow_fifo[fifo_rd_ptr];
            fifo_rd_ptr = (fifo_rd_ptr + 1) % PCF_FIFO_DEPTH;
            fifo_fill--;
          end else if (block_running()) begin
            res.rdata = next_sawtooth();
          end
        end else if (ofs[11:2] < PCF_REG_COUNT) begin
          res.rdata = shadow_regs[ofs[11:2]];
        end
      end
      KIND_WRITE: begin
        if (ofs == OFS_CTRL1) begin
          prior_run = block_running();
          if (wdata[BIT_SOFTRST]) drain_fifo();
          ctrl_new = wdata;
          ctrl_new[BIT_SOFTRST] = 1'b0;
          shadow_regs[WORD_CTRL1] = ctrl_new;
          if (block_running() != prior_run) drain_fifo();
        end else if (ofs != OFS_IDENT && ofs != OFS_CAPS && ofs[11:2] < PCF_REG_COUNT) begin
          shadow_regs[ofs[11:2]] = wdata;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [31:0] ctrl_word(logic en, logic dis, logic srst, logic [1:0] sel);
    logic [31:0] w;
    w = '0;
    w[BIT_ENABLE]     = en;
    w[BIT_DISABLE]    = dis;
    w[BIT_SOFTRST]    = srst;
    w[SEL_LSB +: 2]   = sel;
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %08h want %08h at %0t", what, got, want, $time);
    error_count++;
  endtask

  task automatic send_beat(logic [1:0] kind, logic [11:0] ofs, logic [31:0] wdata);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_offset <= ofs;
    in_wdata  <= wdata;
    do @(posedge clk); while (!in_ready);
    awaited_results.push_back(predict_capture(kind, ofs, wdata));
  endtask

  task automatic send_random_beat();
    int r;
    int sub;
    logic [31:0] w;
    r   = $urandom_range(99);
    sub = $urandom_range(9);
    w   = $urandom;
    if (r < 38) begin
      send_beat(KIND_TICK, 12'($urandom), w);
    end else if (r < 70) begin
      if (sub < 7) send_beat(KIND_READ, 12'($urandom_range(OFS_DATA_LO, OFS_DATA_HI)), w);
      else if (sub == 7) begin
        case ($urandom_range(5))
          0: send_beat(KIND_READ, OFS_IDENT, w);
          1: send_beat(KIND_READ, OFS_CAPS, w);
          2: send_beat(KIND_READ, OFS_STAT, w);
          3: send_beat(KIND_READ, OFS_FIFOSTAT, w);
          4: send_beat(KIND_READ, OFS_FIFOCTL, w);
          default: send_beat(KIND_READ, OFS_CTRL1, w);
        endcase
      end else send_beat(KIND_READ, 12'($urandom), w);
    end else if (r < 95) begin
      if (sub < 4) begin
        w[BIT_ENABLE]  = $urandom_range(99) < 80;
        w[BIT_DISABLE] = $urandom_range(99) < 20;
        w[BIT_SOFTRST] = $urandom_range(99) < 15;
        if ($urandom_range(99) < 60) w[SEL_LSB +: 2] = SEL_DMA;
        send_beat(KIND_WRITE, OFS_CTRL1, w);
      end else if (sub < 6) send_beat(KIND_WRITE, OFS_FIFOCTL, w);
      else if (sub < 9) send_beat(KIND_WRITE, 12'($urandom), w);
      else send_beat(KIND_WRITE, 12'($urandom_range(1, 3)), w);
    end else begin
      send_beat(2'b11, 12'($urandom), w);
    end
  endtask

  always @(posedge clk) begin
    if (hold_arm && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    capture_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected beat rdata", out_rdata, 32'h0);
      end else begin
        want = awaited_results.pop_front();
        if (out_rdata !== want.rdata) report_mismatch("rdata", out_rdata, want.rdata);
        if (out_dma_request !== want.dma_request)
          report_mismatch("dma_request", 32'(out_dma_request), 32'(want.dma_request));
      end
    end
  end

  task automatic test_register_map();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_beat(KIND_READ, OFS_IDENT, 32'h0);
    send_beat(KIND_READ, OFS_CAPS, 32'h0);
    send_beat(KIND_READ, OFS_STAT, 32'h0);
    send_beat(KIND_READ, OFS_FIFOSTAT, 32'h0);
    send_beat(KIND_READ, OFS_CTRL1, 32'h0);
    send_beat(KIND_READ, 12'hFFF, 32'h0);
    send_beat(KIND_WRITE, 12'hFFC, 32'hFFFF_FFFF);
    send_beat(KIND_WRITE, OFS_IDENT, 32'h0);
    send_beat(KIND_READ, OFS_IDENT, 32'h0);
    send_beat(KIND_WRITE, 12'h00C, 32'hFFFF_FFFF);
    send_beat(KIND_READ, 12'h00E, 32'h0);
    send_beat(2'b11, 12'hFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_stopped_block();
    send_beat(KIND_TICK, 12'h000, 32'h0);
    send_beat(KIND_READ, OFS_DATA_LO, 32'h0);
  endtask

  task automatic test_run_stop_and_dma();
    send_beat(KIND_WRITE, OFS_FIFOCTL, 32'h0000_0002);
    send_beat(KIND_WRITE, OFS_CTRL1, ctrl_word(1'b1, 1'b0, 1'b1, SEL_DMA));
    send_beat(KIND_READ, OFS_CTRL1, 32'h0);
    repeat (4) send_beat(KIND_TICK, 12'h000, 32'h0);
    send_beat(KIND_READ, OFS_DATA_HI, 32'h0);
    send_beat(KIND_READ, 12'h027, 32'h0);
    send_beat(KIND_WRITE, OFS_CTRL1, ctrl_word(1'b1, 1'b0, 1'b1, SEL_DMA));
    send_beat(KIND_READ, 12'h030, 32'h0);
    send_beat(KIND_TICK, 12'h000, 32'h0);
    send_beat(KIND_WRITE, 12'h001, ctrl_word(1'b1, 1'b1, 1'b1, 2'b11));
    send_beat(KIND_TICK, 12'h000, 32'h0);
    send_beat(KIND_WRITE, OFS_CTRL1, ctrl_word(1'b1, 1'b1, 1'b0, SEL_DMA));
    send_beat(KIND_READ, OFS_DATA_LO, 32'h0);
  endtask

  task automatic test_fifo_full_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_beat(KIND_WRITE, OFS_FIFOCTL, 32'h0000_001F);
    send_beat(KIND_WRITE, OFS_CTRL1, ctrl_word(1'b1, 1'b0, 1'b0, SEL_DMA));
    hold_arm <= 1'b1;
    repeat (72) send_beat(KIND_TICK, 12'($urandom), $urandom);
    repeat (68) send_beat(KIND_READ, 12'($urandom_range(OFS_DATA_LO, OFS_DATA_HI)), $urandom);
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    send_beat(KIND_WRITE, OFS_CTRL1, ctrl_word(1'b1, 1'b0, 1'b0, SEL_DMA));
    repeat (count) send_random_beat();
  endtask

  initial begin
    int guard;
    foreach (shadow_regs[i]) shadow_regs[i] = 32'h0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_register_map();
    test_stopped_block();
    test_run_stop_and_dma();
    test_fifo_full_backpressure();
    test_random_traffic(0, 0, 245);
    test_random_traffic(62, 0, 245);
    test_random_traffic(0, 62, 245);
    test_random_traffic(7, 7, 245);
    in_valid <= 1'b0;
    guard = 0;
    while (awaited_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch("missing beats", awaited_results.size(), 32'h0);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
